// File: design/dmwb_pkg.sv
// Shared types and constants for the direct-mapped write-back cache.
// Used by the controller, the datapath and the top level; no dependencies.
// Line count and store size are powers of two; the line count stays below 1024.
package dmwb_pkg;

  localparam int LINES       = 32;
  localparam int STORE_WORDS = 1024;
  localparam int ADDR_W      = 10;
  localparam int DATA_W      = 32;
  localparam int INDEX_W     = $clog2(LINES);
  localparam int TAG_W       = ADDR_W - INDEX_W;
  localparam int STORE_AW    = $clog2(STORE_WORDS);

  // s_tdata: address, write_value; m_tdata: read_value, victim_address, victim_value
  localparam int S_TDATA_W = ((ADDR_W + DATA_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((2 * DATA_W + ADDR_W + 7) / 8) * 8;
  localparam int M_TUSER_W = 2;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_WRITEBACK,
    ST_READ,
    ST_UPDATE
  } dmwb_state_t;

  typedef struct packed {
    logic load_req;
    logic lookup;
    logic wb_write;
    logic store_read;
    logic update;
    logic clear_write;
  } dmwb_cmd_t;

  typedef struct packed {
    logic hit;
    logic dirty_victim;
    logic clear_last;
    logic out_busy;
  } dmwb_stat_t;

  // word address to store index, modulo the store size
  function automatic logic [STORE_AW-1:0] store_index(input logic [ADDR_W-1:0] a);
    logic [STORE_AW+ADDR_W-1:0] wide;
    wide = {{STORE_AW{1'b0}}, a};
    return wide[STORE_AW-1:0];
  endfunction

endpackage

// File: design/dmwb_ctrl.sv
// Controller state machine of the direct-mapped write-back cache.
// Depends on dmwb_pkg; drives the datapath by command struct only.
module dmwb_ctrl
  import dmwb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output dmwb_cmd_t  cmd,
  input  dmwb_stat_t stat
);

  dmwb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (stat.hit) state_next = ST_UPDATE;
        else if (stat.dirty_victim) state_next = ST_WRITEBACK;
        else state_next = ST_READ;
      end
      ST_WRITEBACK: state_next = ST_READ;
      ST_READ:      state_next = ST_UPDATE;
      ST_UPDATE: begin
        // hold until the result register frees up
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_CLEAR:     cmd.clear_write = 1'b1;
      ST_IDLE: begin
        s_tready     = 1'b1;
        cmd.load_req = s_tvalid;
      end
      ST_LOOKUP:    cmd.lookup = 1'b1;
      ST_WRITEBACK: cmd.wb_write = 1'b1;
      ST_READ:      cmd.store_read = 1'b1;
      ST_UPDATE:    cmd.update = !stat.out_busy;
      default:      cmd = '0;
    endcase
  end

  a_no_reclear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |=> (state != ST_CLEAR))
    else $error("clearing pass restarted after it finished");

  a_wb_after_lookup: assert property (@(posedge clk) disable iff (rst)
    cmd.wb_write |-> ($past(state) == ST_LOOKUP && $past(stat.dirty_victim)))
    else $error("write-back issued without a dirty victim");

endmodule

// File: design/dmwb_dpath.sv
// Datapath of the direct-mapped write-back cache: request register, line
// memory, valid and dirty bits, backing store and result register. Uses dmwb_pkg.
module dmwb_dpath
  import dmwb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  dmwb_cmd_t            cmd,
  output dmwb_stat_t           stat,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic [M_TUSER_W-1:0] m_tuser
);

  // request register
  logic                     req_func;
  logic [ADDR_W-1:0]        req_addr;
  logic signed [DATA_W-1:0] req_wval;
  logic [INDEX_W-1:0]       req_idx;
  logic [TAG_W-1:0]         req_tag;

  // line memory: tag and word, registered read
  logic [TAG_W-1:0]         line_tag  [LINES];
  logic [DATA_W-1:0]        line_word [LINES];
  logic [TAG_W-1:0]         rd_tag;
  logic [DATA_W-1:0]        rd_word;
  logic [LINES-1:0]         line_valid;
  logic [LINES-1:0]         line_dirty;

  // backing store, single port
  logic [DATA_W-1:0]        store_mem [STORE_WORDS];
  logic [DATA_W-1:0]        store_rd;
  logic [STORE_AW-1:0]      clr_cnt;

  // lookup results
  logic                     r_hit;
  logic                     r_wb;
  logic [ADDR_W-1:0]        r_vaddr;
  logic [DATA_W-1:0]        r_vval;

  // result register
  logic                     out_valid;
  logic [DATA_W-1:0]        out_word;
  logic                     out_hit;
  logic                     out_wb;
  logic [ADDR_W-1:0]        out_vaddr;
  logic [DATA_W-1:0]        out_vval;

  logic [ADDR_W-1:0]        in_addr;
  logic                     hit_now;
  logic [ADDR_W-1:0]        victim_addr;
  logic [DATA_W-1:0]        new_word;

  assign in_addr     = s_tdata[ADDR_W-1:0];
  assign req_idx     = req_addr[INDEX_W-1:0];
  assign req_tag     = req_addr[ADDR_W-1:INDEX_W];
  assign hit_now     = line_valid[req_idx] && (rd_tag == req_tag);
  assign victim_addr = {rd_tag, req_idx};
  assign new_word    = (req_func == FUNC_WRITE) ? req_wval :
                       (r_hit ? rd_word : store_rd);

  assign stat.hit          = hit_now;
  assign stat.dirty_victim = line_valid[req_idx] && line_dirty[req_idx] && !hit_now;
  assign stat.clear_last   = (clr_cnt == STORE_AW'(STORE_WORDS - 1));
  assign stat.out_busy     = out_valid && !m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_func <= s_tuser;
      req_addr <= in_addr;
      req_wval <= s_tdata[ADDR_W +: DATA_W];
      rd_tag   <= line_tag[in_addr[INDEX_W-1:0]];
      rd_word  <= line_word[in_addr[INDEX_W-1:0]];
    end
    if (cmd.lookup) begin
      r_hit   <= hit_now;
      r_wb    <= stat.dirty_victim;
      r_vaddr <= stat.dirty_victim ? victim_addr : '0;
      r_vval  <= stat.dirty_victim ? rd_word : '0;
    end
    // write allocate: fill on any miss, overwrite on any write
    if (cmd.update && (!r_hit || req_func == FUNC_WRITE)) begin
      line_tag[req_idx]  <= req_tag;
      line_word[req_idx] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
      line_dirty <= '0;
    end else if (cmd.update) begin
      line_valid[req_idx] <= 1'b1;
      line_dirty[req_idx] <= (req_func == FUNC_WRITE) || (r_hit && line_dirty[req_idx]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_write) begin
      store_mem[clr_cnt] <= '0;
    end else if (cmd.wb_write) begin
      store_mem[store_index(r_vaddr)] <= r_vval;
    end else if (cmd.store_read) begin
      store_rd <= store_mem[store_index(req_addr)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_write) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_word  <= new_word;
      out_hit   <= r_hit;
      out_wb    <= r_wb;
      out_vaddr <= r_vaddr;
      out_vval  <= r_vval;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'({out_vval, out_vaddr, out_word});
  assign m_tuser  = {out_wb, out_hit};

  a_update_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> line_valid[req_idx])
    else $error("line not valid after update");

  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_wb) |-> (out_vaddr == '0 && out_vval == '0))
    else $error("victim fields set without a write-back");

  a_hit_no_wb: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_wb))
    else $error("hit reported together with a write-back");

endmodule

// File: design/direct_mapped_writeback_cache.sv
// Direct-mapped write-back, write-allocate cache in front of a backing store.
// Each accepted word passes a lookup state, a write-back state on a dirty miss and a
// store read state on any miss, then an update state loading the result register;
// one request at a time through the single-port store, and a result still waiting
// on m_tready holds the next request in its update state. Reset (rst, synchronous):
// lines invalid; then a clearing pass zeroes all 1024 store words, s_tready low.
module direct_mapped_writeback_cache
  import dmwb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // address[9:0], write_value[41:10], zero pad
  input  logic                 s_tuser,  // func (0 read, 1 write)
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // read_value[31:0], victim_address[41:32],
                                         // victim_value[73:42], zero pad
  output logic [M_TUSER_W-1:0] m_tuser   // hit[0], wrote_back[1]
);

  dmwb_cmd_t  cmd;
  dmwb_stat_t stat;

  dmwb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  dmwb_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
